[hdl/bkr_pkg.sv]
package bkr_pkg;

  localparam int CFG_AW = 4;

  localparam logic [2:0] KIND_LOAD_KNOT   = 3'd0;
  localparam logic [2:0] KIND_LOAD_POINT  = 3'd1;
  localparam logic [2:0] KIND_LOAD_INSERT = 3'd2;
  localparam logic [2:0] KIND_START       = 3'd3;
  localparam logic [2:0] KIND_READ_KNOT   = 3'd4;
  localparam logic [2:0] KIND_READ_POINT  = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_DECREASING = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;

  localparam logic [1:0] REG_DEGREE     = 2'd0;
  localparam logic [1:0] REG_NUM_POINTS = 2'd1;
  localparam logic [1:0] REG_NUM_INSERT = 2'd2;

  localparam logic [2:0] DEGREE_RST     = 3'd3;
  localparam logic [6:0] NUM_POINTS_RST = 7'd4;
  localparam logic [4:0] NUM_INSERT_RST = 5'd2;

  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  index;
    logic [31:0] knot_value;
    coord_t      coord_x;
    coord_t      coord_y;
    coord_t      coord_z;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  out_index;
    logic [31:0] out_knot;
    coord_t      out_x;
    coord_t      out_y;
    coord_t      out_z;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [2:0] degree;
    logic [6:0] num_points;
    logic [4:0] num_insert;
  } cfg_t;

endpackage

[hdl/bkr_ram.sv]
module bkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bkr_div.sv]
module bkr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic        run;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] sh;
  logic        ge;

  // remainder stays below the divisor, so one spare bit covers the shift
  assign sh = {rem, 1'b0};
  assign ge = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= num;
        dsr  <= den;
        quot <= '0;
        cnt  <= '0;
      end else if (run) begin
        rem  <= ge ? 32'(sh - {1'b0, dsr}) : sh[31:0];
        quot <= {quot[30:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/bkr_blend.sv]
module bkr_blend import bkr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  logic [31:0] alpha,
  input  point_t      pa,
  input  point_t      pb,
  output logic        valid_out,
  output point_t      res
);

  coord_t a_c [3];
  coord_t b_c [3];
  coord_t b_q [3];
  coord_t r_c [3];
  logic signed [65:0] prod [3];
  logic v1;

  assign a_c[0] = pa.x;
  assign a_c[1] = pa.y;
  assign a_c[2] = pa.z;
  assign b_c[0] = pb.x;
  assign b_c[1] = pb.y;
  assign b_c[2] = pb.z;

  // b + alpha*(a-b), rounded half up at the Q1.31 point
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [32:0] diff;
    logic signed [65:0] sum;

    assign diff = $signed({a_c[c][31], a_c[c]}) - $signed({b_c[c][31], b_c[c]});

    always_ff @(posedge clk) begin
      prod[c] <= $signed({1'b0, alpha}) * diff;
      b_q[c]  <= b_c[c];
    end

    assign sum    = prod[c] + 66'sd1073741824;
    assign r_c[c] = b_q[c] + coord_t'(sum[62:31]);
  end

  always_ff @(posedge clk) begin
    res <= '{x: r_c[0], y: r_c[1], z: r_c[2]};
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1        <= valid_in;
      valid_out <= v1;
    end
  end

endmodule

[hdl/bkr_cfg.sv]
module bkr_cfg import bkr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] ra;

  assign ra     = paddr[CFG_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{degree: DEGREE_RST, num_points: NUM_POINTS_RST, num_insert: NUM_INSERT_RST};
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        REG_DEGREE:     cfg.degree     <= pwdata[2:0];
        REG_NUM_POINTS: cfg.num_points <= pwdata[6:0];
        REG_NUM_INSERT: cfg.num_insert <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      REG_DEGREE:     prdata = 32'(cfg.degree);
      REG_NUM_POINTS: prdata = 32'(cfg.num_points);
      REG_NUM_INSERT: prdata = 32'(cfg.num_insert);
      default:        prdata = '0;
    endcase
  end

endmodule

[hdl/bspline_knot_refinement.sv]
// Loads and read-backs: one transfer a cycle while idle; a read result strobes on done in the
// cycle after the read. Start: busy through the knot check, the span searches and the copy of
// the kept entries, then per inserted knot through the shifts and blends, paced by the 31-step
// divider and the single read port of the point memory; done strobes in the first
// cycle with busy low. Reset: degree 3, num_points 4, num_insert 2, status 0; memories hold
// nothing until loaded. The receiver cannot stall: every result is shown for exactly one cycle.
module bspline_knot_refinement import bkr_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DEGREE = 7,
  parameter int MAX_INSERT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output res_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int KD   = MAX_POINTS + MAX_DEGREE + 1;
  localparam int NKD  = KD + MAX_INSERT;
  localparam int NPD  = MAX_POINTS + MAX_INSERT;
  localparam int KAW  = $clog2(KD);
  localparam int PAW  = $clog2(MAX_POINTS);
  localparam int IAW  = (MAX_INSERT > 1) ? $clog2(MAX_INSERT) : 1;
  localparam int NKAW = $clog2(NKD);
  localparam int NPAW = $clog2(NPD);
  localparam int IW0  = $clog2(2 * MAX_POINTS + 2 * MAX_DEGREE + MAX_INSERT + 2) + 1;
  localparam int IW   = (IW0 > 8) ? IW0 : 8;

  typedef logic signed [IW-1:0] idx_t;

  localparam idx_t ZERO = idx_t'(0);
  localparam idx_t ONE  = idx_t'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_CHK_RD, S_CHK_EV, S_XC_RD, S_XC_EV,
    S_SP_INIT, S_SP_RD, S_SP_EV, S_SP_END,
    S_CP_SET, S_CP_RD, S_CP_WR,
    S_M_J, S_M_X, S_M_W, S_M_WC, S_M_WP, S_M_S, S_M_S2,
    S_M_L, S_M_LA, S_M_LD, S_M_LB, S_M_LB2, S_M_LB3, S_M_LBW, S_M_E,
    S_FIN
  } state_t;

  function automatic logic in_rng(idx_t v, int depth);
    in_rng = (v >= ZERO) && (v < idx_t'(depth));
  endfunction

  cfg_t   cfg;
  state_t state;

  idx_t n_c, p_c, r_c;
  idx_t n, p, r, m, i, k, j, l, a, b, lo, hi, mid, mid_c, cj, cend, coff;
  logic [1:0]  cph;
  logic        which;
  logic [31:0] x, x0, xl, sx, up, un, prev, alpha;
  point_t      pa;
  logic [1:0]  err, err_flag;
  logic        rd_knot, rd_point, rd_start;
  logic [6:0]  rd_idx;

  idx_t uk_ra, op_ra, ik_ra, nk_ra, np_ra;
  idx_t uk_wa, op_wa, ik_wa, nk_wa, np_wa;
  logic uk_wv, op_wv, ik_wv, nk_wv, np_wv;
  logic uk_ok, op_ok, ik_ok, nk_ok, np_ok;
  logic [31:0] nk_wd;
  point_t      np_wd, cmd_pt;

  logic [31:0] uk_rd, ik_rd, nk_rd, uk_q, ik_q, nk_q;
  point_t      op_rd, np_rd, op_q, np_q;

  logic signed [32:0] num_c, den_c;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        bl_valid, bl_done;
  point_t      bl_res;

  bkr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bkr_div u_div (
    .clk, .rst, .start(div_start), .num(num_c[31:0]), .den(den_c[31:0]),
    .done(div_done), .quot(div_q)
  );

  bkr_blend u_blend (
    .clk, .rst, .valid_in(bl_valid), .alpha, .pa, .pb(np_q),
    .valid_out(bl_done), .res(bl_res)
  );

  bkr_ram #(.WIDTH(32), .DEPTH(KD)) u_old_knots (
    .clk, .we(uk_wv && in_rng(uk_wa, KD)), .waddr(KAW'(uk_wa)), .wdata(cmd.knot_value),
    .raddr(KAW'(uk_ra)), .rdata(uk_rd)
  );

  bkr_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_old_points (
    .clk, .we(op_wv && in_rng(op_wa, MAX_POINTS)), .waddr(PAW'(op_wa)), .wdata(cmd_pt),
    .raddr(PAW'(op_ra)), .rdata(op_rd)
  );

  bkr_ram #(.WIDTH(32), .DEPTH(MAX_INSERT)) u_insert_knots (
    .clk, .we(ik_wv && in_rng(ik_wa, MAX_INSERT)), .waddr(IAW'(ik_wa)),
    .wdata(cmd.knot_value), .raddr(IAW'(ik_ra)), .rdata(ik_rd)
  );

  bkr_ram #(.WIDTH(32), .DEPTH(NKD)) u_new_knots (
    .clk, .we(nk_wv && in_rng(nk_wa, NKD)), .waddr(NKAW'(nk_wa)), .wdata(nk_wd),
    .raddr(NKAW'(nk_ra)), .rdata(nk_rd)
  );

  bkr_ram #(.WIDTH(96), .DEPTH(NPD)) u_new_points (
    .clk, .we(np_wv && in_rng(np_wa, NPD)), .waddr(NPAW'(np_wa)), .wdata(np_wd),
    .raddr(NPAW'(np_ra)), .rdata(np_rd)
  );

  // out-of-range reads give zero
  always_ff @(posedge clk) begin
    uk_ok <= in_rng(uk_ra, KD);
    op_ok <= in_rng(op_ra, MAX_POINTS);
    ik_ok <= in_rng(ik_ra, MAX_INSERT);
    nk_ok <= in_rng(nk_ra, NKD);
    np_ok <= in_rng(np_ra, NPD);
  end

  assign uk_q = uk_ok ? uk_rd : '0;
  assign op_q = op_ok ? op_rd : '0;
  assign ik_q = ik_ok ? ik_rd : '0;
  assign nk_q = nk_ok ? nk_rd : '0;
  assign np_q = np_ok ? np_rd : '0;

  assign cmd_pt = '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
  assign busy   = (state != S_IDLE);
  assign sx     = which ? xl : x0;
  assign mid_c  = (lo + hi + ONE) >>> 1;
  assign num_c  = $signed({1'b0, nk_q}) - $signed({1'b0, x});
  assign den_c  = $signed({1'b0, nk_q}) - $signed({1'b0, uk_q});

  always_comb begin
    int nn, pp, rr;
    nn = int'(cfg.num_points);
    if (nn < 2) nn = 2;
    if (nn > MAX_POINTS) nn = MAX_POINTS;
    pp = int'(cfg.degree);
    if (pp < 1) pp = 1;
    if (pp > MAX_DEGREE) pp = MAX_DEGREE;
    if (pp > nn - 1) pp = nn - 1;
    rr = int'(cfg.num_insert);
    if (rr < 1) rr = 1;
    if (rr > MAX_INSERT) rr = MAX_INSERT;
    n_c = idx_t'(nn);
    p_c = idx_t'(pp);
    r_c = idx_t'(rr);
  end

  // memory port steering
  always_comb begin
    uk_ra = ZERO;  op_ra = ZERO;  ik_ra = ZERO;
    nk_ra = idx_t'(cmd.index);
    np_ra = idx_t'(cmd.index);
    uk_wa = idx_t'(cmd.index);
    op_wa = idx_t'(cmd.index);
    ik_wa = idx_t'(cmd.index);
    nk_wa = k;
    np_wa = k - p - ONE;
    uk_wv = 1'b0;  op_wv = 1'b0;  ik_wv = 1'b0;  nk_wv = 1'b0;  np_wv = 1'b0;
    nk_wd = uk_q;
    np_wd = op_q;
    div_start = 1'b0;
    bl_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        uk_wv = start && (cmd.kind == KIND_LOAD_KNOT);
        op_wv = start && (cmd.kind == KIND_LOAD_POINT);
        ik_wv = start && (cmd.kind == KIND_LOAD_INSERT);
      end
      S_CHK_RD: uk_ra = i;
      S_XC_RD:  ik_ra = j;
      S_SP_RD:  uk_ra = mid_c;
      S_CP_RD: begin
        op_ra = cj;
        uk_ra = cj;
      end
      S_CP_WR: begin
        nk_wa = cj + coff;
        np_wa = cj + coff;
        np_wv = (cph < 2'd2);
        nk_wv = (cph >= 2'd2);
      end
      S_M_J: ik_ra = j;
      S_M_W: uk_ra = i;
      S_M_WC: begin
        nk_wv = (x <= uk_q);
        op_ra = i - p - ONE;
      end
      S_M_WP: np_wv = 1'b1;
      S_M_S:  np_ra = k - p;
      S_M_S2: begin
        np_wv = 1'b1;
        np_wd = np_q;
      end
      S_M_L: begin
        nk_ra = k + l;
        uk_ra = i - p + l;
      end
      S_M_LA: begin
        div_start = (num_c > 0) && (den_c > 0) && (num_c < den_c);
      end
      S_M_LB:  np_ra = k - p + l - ONE;
      S_M_LB2: np_ra = k - p + l;
      S_M_LB3: bl_valid = 1'b1;
      S_M_LBW: begin
        np_wv = bl_done;
        np_wa = k - p + l - ONE;
        np_wd = bl_res;
      end
      S_M_E: begin
        nk_wv = 1'b1;
        nk_wd = x;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_flag <= ST_OK;
      rd_knot  <= 1'b0;
      rd_point <= 1'b0;
      rd_start <= 1'b0;
    end else begin
      rd_knot  <= 1'b0;
      rd_point <= 1'b0;
      rd_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rd_knot  <= (cmd.kind == KIND_READ_KNOT);
            rd_point <= (cmd.kind == KIND_READ_POINT);
            rd_idx   <= cmd.index;
            if (cmd.kind == KIND_START) state <= S_INIT;
          end
        end
        S_INIT: begin
          n     <= n_c;
          p     <= p_c;
          r     <= r_c;
          m     <= n_c + p_c + ONE;
          i     <= ZERO;
          err   <= ST_OK;
          state <= S_CHK_RD;
        end
        S_CHK_RD: state <= S_CHK_EV;
        S_CHK_EV: begin
          if (i == p) up <= uk_q;
          if (i == n) un <= uk_q;
          prev <= uk_q;
          if (i != ZERO && prev > uk_q) begin
            err   <= ST_DECREASING;
            state <= S_FIN;
          end else if (i == m - ONE) begin
            j     <= ZERO;
            state <= S_XC_RD;
          end else begin
            i     <= i + ONE;
            state <= S_CHK_RD;
          end
        end
        S_XC_RD: state <= S_XC_EV;
        S_XC_EV: begin
          if (ik_q < up || ik_q > un) begin
            err   <= ST_RANGE;
            state <= S_FIN;
          end else begin
            if (j == ZERO) x0 <= ik_q;
            if (j == r - ONE) begin
              xl    <= ik_q;
              which <= 1'b0;
              state <= S_SP_INIT;
            end else begin
              j     <= j + ONE;
              state <= S_XC_RD;
            end
          end
        end
        S_SP_INIT: begin
          // the last knot of the range belongs to the last span
          if (sx == un) begin
            lo    <= n - ONE;
            state <= S_SP_END;
          end else begin
            lo    <= p;
            hi    <= n - ONE;
            state <= S_SP_RD;
          end
        end
        S_SP_RD: begin
          if (lo == hi) begin
            state <= S_SP_END;
          end else begin
            mid   <= mid_c;
            state <= S_SP_EV;
          end
        end
        S_SP_EV: begin
          if (uk_q <= sx) lo <= mid;
          else hi <= mid - ONE;
          state <= S_SP_RD;
        end
        S_SP_END: begin
          if (!which) begin
            a     <= lo;
            which <= 1'b1;
            state <= S_SP_INIT;
          end else begin
            b     <= lo + ONE;
            cph   <= 2'd0;
            state <= S_CP_SET;
          end
        end
        S_CP_SET: begin
          case (cph)
            2'd0: begin cj <= ZERO;      cend <= a - p;     coff <= ZERO; end
            2'd1: begin cj <= b - ONE;   cend <= n - ONE;   coff <= r;    end
            2'd2: begin cj <= ZERO;      cend <= a;         coff <= ZERO; end
            default: begin cj <= b + p;  cend <= m - ONE;   coff <= r;    end
          endcase
          state <= S_CP_RD;
        end
        S_CP_RD: begin
          if (cj > cend) begin
            if (cph == 2'd3) begin
              i     <= b + p - ONE;
              k     <= b + p + r - ONE;
              j     <= r - ONE;
              state <= S_M_J;
            end else begin
              cph   <= cph + 2'd1;
              state <= S_CP_SET;
            end
          end else begin
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          cj    <= cj + ONE;
          state <= S_CP_RD;
        end
        S_M_J: state <= S_M_X;
        S_M_X: begin
          x     <= ik_q;
          state <= S_M_W;
        end
        S_M_W: state <= (i > a) ? S_M_WC : S_M_S;
        S_M_WC: state <= (x <= uk_q) ? S_M_WP : S_M_S;
        S_M_WP: begin
          k     <= k - ONE;
          i     <= i - ONE;
          state <= S_M_W;
        end
        S_M_S:  state <= S_M_S2;
        S_M_S2: begin
          l     <= ONE;
          state <= S_M_L;
        end
        S_M_L: state <= (l > p) ? S_M_E : S_M_LA;
        S_M_LA: begin
          // non-positive numerator copies the right neighbour, same as alpha zero
          if (num_c <= 0) begin
            alpha <= '0;
            state <= S_M_LB;
          end else if (den_c <= 0 || num_c >= den_c) begin
            alpha <= Q_ONE;
            state <= S_M_LB;
          end else begin
            state <= S_M_LD;
          end
        end
        S_M_LD: begin
          if (div_done) begin
            alpha <= div_q;
            state <= S_M_LB;
          end
        end
        S_M_LB:  state <= S_M_LB2;
        S_M_LB2: begin
          pa    <= np_q;
          state <= S_M_LB3;
        end
        S_M_LB3: state <= S_M_LBW;
        S_M_LBW: begin
          if (bl_done) begin
            l     <= l + ONE;
            state <= S_M_L;
          end
        end
        S_M_E: begin
          k <= k - ONE;
          if (j == ZERO) begin
            state <= S_FIN;
          end else begin
            j     <= j - ONE;
            state <= S_M_J;
          end
        end
        S_FIN: begin
          err_flag <= err;
          rd_start <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done = rd_knot || rd_point || rd_start;

  always_comb begin
    result.out_index = rd_start ? '0 : rd_idx;
    result.out_knot  = rd_knot ? nk_q : '0;
    result.out_x     = rd_point ? np_q.x : '0;
    result.out_y     = rd_point ? np_q.y : '0;
    result.out_z     = rd_point ? np_q.z : '0;
    result.status    = err_flag;
  end

endmodule

[tb/bkr_checker.sv]
`timescale 1ns / 1ps
module bkr_checker import bkr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  cmd_t              cmd,
  input  logic              done,
  input  res_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fails,
  output int                pending
);

  localparam int MAXP   = 64;
  localparam int MAXD   = 7;
  localparam int MAXI   = 16;
  localparam int OLD_KD = MAXP + MAXD + 1;
  localparam int NEW_KD = OLD_KD + MAXI;
  localparam int NEW_PD = MAXP + MAXI;

  logic [31:0] old_knot [OLD_KD];
  point_t      old_pt   [MAXP];
  logic [31:0] ins_knot [MAXI];
  logic [31:0] new_knot [NEW_KD];
  point_t      new_pt   [NEW_PD];
  logic [1:0]  err_state;
  logic [2:0]  deg;
  logic [6:0]  npts;
  logic [4:0]  nins;
  res_t        expected_q [$];

  function automatic logic [31:0] knot_at(int i);
    return (i >= 0 && i < OLD_KD) ? old_knot[i] : 32'd0;
  endfunction

  function automatic logic [31:0] ins_at(int i);
    return (i >= 0 && i < MAXI) ? ins_knot[i] : 32'd0;
  endfunction

  function automatic logic [31:0] newk_at(int i);
    return (i >= 0 && i < NEW_KD) ? new_knot[i] : 32'd0;
  endfunction

  function automatic void set_newk(int i, logic [31:0] v);
    if (i >= 0 && i < NEW_KD) new_knot[i] = v;
  endfunction

  function automatic point_t oldp_at(int i);
    return (i >= 0 && i < MAXP) ? old_pt[i] : '0;
  endfunction

  function automatic point_t newp_at(int i);
    return (i >= 0 && i < NEW_PD) ? new_pt[i] : '0;
  endfunction

  function automatic void set_newp(int i, point_t v);
    if (i >= 0 && i < NEW_PD) new_pt[i] = v;
  endfunction

  // alpha*a + (1-alpha)*b in Q1.31, rounded half up
  function automatic coord_t mix(longint alpha, coord_t a, coord_t b);
    longint s;
    s = alpha * longint'(a) + (64'sd2147483648 - alpha) * longint'(b);
    return coord_t'((s + 64'sd1073741824) >>> 31);
  endfunction

  function automatic int span_of(logic [31:0] x, int n, int p);
    int s;
    s = p;
    if (x == knot_at(n)) return n - 1;
    for (int i = p; i < n; i++)
      if (knot_at(i) <= x && x < knot_at(i + 1)) s = i;
    return s;
  endfunction

  function automatic logic [1:0] refine_curve();
    int n, p, r, m, a, b, i, k, d;
    longint num, den, alpha;
    logic [31:0] x;
    point_t lp, rp, bp;
    n = npts;
    if (n < 2) n = 2;
    if (n > MAXP) n = MAXP;
    p = deg;
    if (p < 1) p = 1;
    if (p > MAXD) p = MAXD;
    if (p > n - 1) p = n - 1;
    r = nins;
    if (r < 1) r = 1;
    if (r > MAXI) r = MAXI;
    m = n + p + 1;
    for (int j = 0; j < m - 1; j++)
      if (knot_at(j) > knot_at(j + 1)) return ST_DECREASING;
    for (int j = 0; j < r; j++)
      if (ins_at(j) < knot_at(p) || ins_at(j) > knot_at(n)) return ST_RANGE;
    a = span_of(ins_at(0), n, p);
    b = span_of(ins_at(r - 1), n, p) + 1;
    for (int j = 0; j <= a - p; j++) set_newp(j, oldp_at(j));
    for (int j = b - 1; j < n; j++) set_newp(j + r, oldp_at(j));
    for (int j = 0; j <= a; j++) set_newk(j, knot_at(j));
    for (int j = b + p; j < m; j++) set_newk(j + r, knot_at(j));
    i = b + p - 1;
    k = b + p + r - 1;
    for (int j = r - 1; j >= 0; j--) begin
      x = ins_at(j);
      while (x <= knot_at(i) && i > a) begin
        set_newp(k - p - 1, oldp_at(i - p - 1));
        set_newk(k, knot_at(i));
        k--;
        i--;
      end
      set_newp(k - p - 1, newp_at(k - p));
      for (int l = 1; l <= p; l++) begin
        d = k - p + l;
        num = newk_at(k + l);
        num = num - x;
        if (num == 0) begin
          set_newp(d - 1, newp_at(d));
        end else begin
          den = newk_at(k + l);
          den = den - knot_at(i - p + l);
          if (num < 0) alpha = 0;
          else if (den <= 0 || num >= den) alpha = 64'sd2147483648;
          else alpha = (num <<< 31) / den;
          lp = newp_at(d - 1);
          rp = newp_at(d);
          bp.x = mix(alpha, lp.x, rp.x);
          bp.y = mix(alpha, lp.y, rp.y);
          bp.z = mix(alpha, lp.z, rp.z);
          set_newp(d - 1, bp);
        end
      end
      set_newk(k, x);
      k--;
    end
    return ST_OK;
  endfunction

  function automatic void predict(cmd_t c);
    res_t e;
    point_t pt;
    e = '0;
    case (c.kind)
      KIND_LOAD_KNOT: if (c.index < OLD_KD) old_knot[c.index] = c.knot_value;
      KIND_LOAD_POINT: if (c.index < MAXP) old_pt[c.index] = {c.coord_x, c.coord_y, c.coord_z};
      KIND_LOAD_INSERT: if (c.index < MAXI) ins_knot[c.index] = c.knot_value;
      KIND_START: begin
        err_state = refine_curve();
        e.status = err_state;
        expected_q.push_back(e);
      end
      KIND_READ_KNOT: begin
        e.out_index = c.index;
        e.out_knot = newk_at(c.index);
        e.status = err_state;
        expected_q.push_back(e);
      end
      KIND_READ_POINT: begin
        pt = newp_at(c.index);
        e.out_index = c.index;
        e.out_x = pt.x;
        e.out_y = pt.y;
        e.out_z = pt.z;
        e.status = err_state;
        expected_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    res_t e;
    int errs;
    errs = 0;
    if (rst) begin
      expected_q.delete();
      err_state = ST_OK;
      deg = DEGREE_RST;
      npts = NUM_POINTS_RST;
      nins = NUM_INSERT_RST;
      fails <= 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (result.out_index !== e.out_index) begin
            $error("out_index: expected %0d, got %0d", e.out_index, result.out_index);
            errs++;
          end
          if (result.out_knot !== e.out_knot) begin
            $error("out_knot: expected %h, got %h", e.out_knot, result.out_knot);
            errs++;
          end
          if (result.out_x !== e.out_x) begin
            $error("out_x: expected %h, got %h", e.out_x, result.out_x);
            errs++;
          end
          if (result.out_y !== e.out_y) begin
            $error("out_y: expected %h, got %h", e.out_y, result.out_y);
            errs++;
          end
          if (result.out_z !== e.out_z) begin
            $error("out_z: expected %h, got %h", e.out_z, result.out_z);
            errs++;
          end
          if (result.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, result.status);
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DEGREE:     deg = pwdata[2:0];
          REG_NUM_POINTS: npts = pwdata[6:0];
          REG_NUM_INSERT: nins = pwdata[4:0];
          default: ;
        endcase
      end
      if (start && !busy) predict(cmd);
      fails <= fails + errs;
    end
    pending <= expected_q.size();
  end

endmodule

[tb/bspline_knot_refinement_tb.sv]
`timescale 1ns / 1ps
module bspline_knot_refinement_tb import bkr_pkg::*;;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  cmd_t              cmd;
  logic              done;
  res_t              result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fails;
  int                pending;
  int                items;
  bit                quiet;
  int                kmax;
  int                pmax;

  bspline_knot_refinement u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bkr_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd2_500_000 * 8);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t mk(logic [2:0] kind, int idx, logic [31:0] kv);
    cmd_t c;
    c.kind = kind;
    c.index = idx[6:0];
    c.knot_value = kv;
    c.coord_x = rand_coord();
    c.coord_y = rand_coord();
    c.coord_z = rand_coord();
    return c;
  endfunction

  task automatic issue(input cmd_t c);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // hold off until nothing is in flight, then let the block settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic noise();
    case ($urandom_range(0, 4))
      0: issue(mk(3'd6, $urandom_range(0, 127), $urandom));
      1: issue(mk(3'd7, $urandom_range(0, 127), $urandom));
      2: issue(mk(KIND_LOAD_KNOT, $urandom_range(72, 127), $urandom));
      3: issue(mk(KIND_LOAD_POINT, $urandom_range(64, 127), $urandom));
      default: issue(mk(KIND_LOAD_INSERT, $urandom_range(16, 127), $urandom));
    endcase
  endtask

  task automatic read_back(input int count);
    int idx;
    bit pick_knot;
    for (int j = 0; j < count; j++) begin
      pick_knot = $urandom_range(0, 1);
      if (pick_knot) begin
        idx = (kmax == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(88, 127)
                                                       : $urandom_range(0, kmax - 1);
        issue(mk(KIND_READ_KNOT, idx, $urandom));
      end else begin
        idx = (pmax == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(80, 127)
                                                       : $urandom_range(0, pmax - 1);
        issue(mk(KIND_READ_POINT, idx, $urandom));
      end
    end
  endtask

  // err: 0 well formed, 1 decreasing knot vector, 2 inserted knot out of range
  task automatic run_case(input int rd, input int rn, input int rr, input int err);
    logic [31:0] u [72];
    logic [31:0] xs [$];
    logic [31:0] lo, hi;
    longint cur;
    int n, p, r, m, j;
    bit clamped;
    drain();
    cfg_write(REG_DEGREE, rd);
    cfg_write(REG_NUM_POINTS, rn);
    cfg_write(REG_NUM_INSERT, rr);
    n = rn < 2 ? 2 : (rn > 64 ? 64 : rn);
    p = rd < 1 ? 1 : rd;
    if (p > n - 1) p = n - 1;
    r = rr < 1 ? 1 : (rr > 16 ? 16 : rr);
    m = n + p + 1;
    clamped = $urandom_range(0, 2) != 0;
    cur = $urandom_range(0, 2) == 0 ? $urandom_range(0, 32'h0100_0000) : 0;
    for (int i = 0; i < m; i++) begin
      if (!(clamped && (i <= p || i > n))) begin
        if (clamped && i == n && $urandom_range(0, 1)) cur = 64'd2147483648;
        else if (i > 0 && $urandom_range(0, 3) != 0)
          cur = cur + $urandom_range(1, 32'h8000_0000 / m);
        if (cur > 64'd2147483648) cur = 64'd2147483648;
      end
      u[i] = cur[31:0];
    end
    lo = u[p];
    hi = u[n];
    for (int i = 0; i < r; i++) begin
      case ($urandom_range(0, 7))
        0, 1: xs.push_back(u[$urandom_range(p, n)]);
        2: xs.push_back(lo);
        3: xs.push_back(hi);
        default: xs.push_back($urandom_range(hi, lo));
      endcase
    end
    xs.sort();
    if (err == 1) begin
      j = $urandom_range(0, m - 2);
      u[j] = u[j + 1] + 1 + $urandom_range(0, 1000);
    end else if (err == 2) begin
      j = $urandom_range(0, r - 1);
      xs[j] = (lo != 0 && $urandom_range(0, 1)) ? lo - 1 : hi + 1 + $urandom_range(0, 1000);
    end
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 9) == 0) noise();
      issue(mk(KIND_LOAD_KNOT, i, u[i]));
    end
    for (int i = 0; i < n; i++) issue(mk(KIND_LOAD_POINT, i, $urandom));
    for (int i = 0; i < r; i++) issue(mk(KIND_LOAD_INSERT, i, xs[i]));
    issue(mk(KIND_START, $urandom_range(0, 127), $urandom));
    if (err == 0) begin
      if (m + r > kmax) kmax = m + r;
      if (n + r > pmax) pmax = n + r;
    end
    read_back($urandom_range(2, 8));
  endtask

  initial begin
    int rn, rr;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items = 0;
    quiet = 1'b0;
    kmax = 0;
    pmax = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing refined yet: only reads past the arrays, plus unused kinds
    issue(mk(KIND_READ_KNOT, 127, 32'hffff_ffff));
    issue(mk(KIND_READ_POINT, 80, 32'h0));
    issue(mk(3'd6, 0, 32'h0));
    issue(mk(3'd7, 127, 32'h8000_0000));
    run_case(3, 4, 2, 0);

    run_case(7, 64, 16, 0);
    run_case(0, 2, 1, 0);
    run_case(7, 127, 31, 0);
    run_case(1, 64, 0, 0);
    run_case(7, 3, 5, 0);
    run_case(3, 6, 2, 1);
    run_case(2, 5, 3, 2);

    while (items < 1250) begin
      if (items > 1100) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        rn = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
        rr = $urandom_range(0, 1) ? 16 : $urandom_range(17, 31);
      end else begin
        rn = $urandom_range(0, 10);
        rr = $urandom_range(0, 4);
      end
      case ($urandom_range(0, 9))
        0: run_case($urandom_range(0, 7), rn, rr, 1);
        1: run_case($urandom_range(0, 7), rn, rr, 2);
        default: run_case($urandom_range(0, 7), rn, rr, 0);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        issue(mk(KIND_START, $urandom_range(0, 127), $urandom));
        read_back($urandom_range(1, 4));
      end
    end

    drain();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bkr_pkg.sv
hdl/bkr_ram.sv
hdl/bkr_div.sv
hdl/bkr_blend.sv
hdl/bkr_cfg.sv
hdl/bspline_knot_refinement.sv
tb/bkr_checker.sv
tb/bspline_knot_refinement_tb.sv
